// ----- hw/rtl/dsh_pkg.sv -----
// Shared types, register codes and the half-step phase table of the door stepper controller.
package dsh_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	// Register indexes of the configuration port.
	localparam logic [CfgIdxW-1:0] REG_TRAVEL_STEPS  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_STEP_PERIOD   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_CTRL_PERIOD   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_HOUR_PERIODS  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_FORCE_HOURS   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_FORCE_HOLD    = 3'd5;

	// Register values after reset.
	localparam logic [15:0] TRAVEL_STEPS_RST  = 16'd1000;
	localparam logic [7:0]  STEP_PERIOD_RST   = 8'd3;
	localparam logic [7:0]  CTRL_PERIOD_RST   = 8'd100;
	localparam logic [15:0] HOUR_PERIODS_RST  = 16'd36000;
	localparam logic [7:0]  FORCE_HOURS_RST   = 8'd24;
	localparam logic [15:0] FORCE_HOLD_RST    = 16'd70;

	typedef struct packed {
		logic       open_write;
		logic       open_value;
		logic       ice_out;
		logic       delay_write;
		logic [7:0] delay_value;
		logic       force_write;
		logic       force_value;
	} dsh_in_t;

	typedef struct packed {
		logic [3:0]  coils;
		logic [15:0] position;
		logic        door_open;
		logic        opening_latched;
		logic        force_pending;
		logic        force_active;
	} dsh_out_t;

	typedef struct packed {
		logic [15:0] travel_steps;
		logic [7:0]  step_period_ticks;
		logic [7:0]  control_period_ticks;
		logic [15:0] hour_periods;
		logic [7:0]  forced_close_hours;
		logic [15:0] forced_close_hold;
	} dsh_cfg_t;

	// Motor side state: position, direction and coil drive.
	typedef struct packed {
		logic [15:0] position;
		logic        open_flag;
		logic        direction_latch;
		logic [3:0]  coils;
	} dsh_motor_t;

	// Slow control side state: close delay, idle timer and forced close.
	typedef struct packed {
		logic [7:0]  close_delay;
		logic [15:0] period_count;
		logic [7:0]  hour_count;
		logic        force_flag;
		logic [15:0] hold_count;
	} dsh_timer_t;

	// Eight-phase half-step drive pattern, indexed by position mod 8.
	function automatic logic [3:0] phase_coils(input logic [2:0] phase);
		logic [3:0] c;
		case (phase)
			3'd0: c = 4'h1;
			3'd1: c = 4'h9;
			3'd2: c = 4'h8;
			3'd3: c = 4'hC;
			3'd4: c = 4'h4;
			3'd5: c = 4'h6;
			3'd6: c = 4'h2;
			3'd7: c = 4'h3;
			default: c = 4'h0;
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/door_stepper_half_step_controller.sv -----
// Top level of the door stepper half-step controller: registers, handshake and config port.
//
//  Channel  | Signals                         | Word
//  ---------+---------------------------------+------------------------------
//  in       | in_valid, in_stall, in_word     | one 1 ms tick with its writes
//  out      | out_valid, out_stall, out_word  | coils, position and status
//  cfg      | cfg_we, cfg_index, cfg_data     | one register write, no wait
//
// One word is taken every clock while in_stall is low. A word is held in the
// input register and is then worked on in a single pass of counters and
// compares, whose result lands in the output register. The state update of
// one tick is the whole work, so ticks follow each other at one per clock
// while out is not stalled. The output register holds a result while out is
// stalled; the input register keeps taking words until both registers are full.
// Reset clears the valid flags, tick dividers, motor and timer state and loads the register defaults; no clearing pass.
module door_stepper_half_step_controller import dsh_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dsh_in_t             in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output dsh_out_t            out_word,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	dsh_cfg_t   cfg_q;
	dsh_in_t    word_s1;
	logic       valid_s1;
	logic [7:0] step_tick_q;
	logic [7:0] ctrl_tick_q;
	dsh_motor_t motor_q;
	dsh_timer_t timer_q;
	dsh_out_t   result_q;
	logic       out_valid_q;

	logic       advance;
	logic       work;
	dsh_motor_t motor_cur;
	dsh_timer_t timer_cur;
	dsh_motor_t motor_nxt;
	dsh_timer_t timer_nxt;
	logic [7:0] step_tick_nxt;
	logic [7:0] ctrl_tick_nxt;
	logic       load_travel;
	logic [15:0] position_nxt;
	dsh_motor_t motor_upd;

	// The output register can take a new result when it is empty or drained.
	assign advance   = !out_valid_q || !out_stall;
	assign work      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_word  = result_q;

	// The writes carried in the tick word come first.
	always_comb begin
		motor_cur = motor_q;
		timer_cur = timer_q;
		if (word_s1.open_write) begin
			motor_cur.open_flag = word_s1.open_value;
		end
		if (word_s1.delay_write) begin
			timer_cur.close_delay = word_s1.delay_value;
		end
		if (word_s1.force_write) begin
			timer_cur.force_flag = word_s1.force_value;
		end
	end

	dsh_motor u_motor (
		.cfg            (cfg_q),
		.step_tick      (step_tick_q),
		.cur            (motor_cur),
		.close_delay    (timer_cur.close_delay),
		.ice_out        (word_s1.ice_out),
		.step_tick_next (step_tick_nxt),
		.nxt            (motor_nxt)
	);

	dsh_timer u_timer (
		.cfg            (cfg_q),
		.ctrl_tick      (ctrl_tick_q),
		.cur            (timer_cur),
		.ice_out        (word_s1.ice_out),
		.ctrl_tick_next (ctrl_tick_nxt),
		.nxt            (timer_nxt),
		.load_travel    (load_travel)
	);

	// A forced close run overrides the position after the half step; the
	// coil drive keeps what the half step left.
	assign position_nxt = load_travel ? cfg_q.travel_steps : motor_nxt.position;

	always_comb begin
		motor_upd          = motor_nxt;
		motor_upd.position = position_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.travel_steps         <= TRAVEL_STEPS_RST;
			cfg_q.step_period_ticks    <= STEP_PERIOD_RST;
			cfg_q.control_period_ticks <= CTRL_PERIOD_RST;
			cfg_q.hour_periods         <= HOUR_PERIODS_RST;
			cfg_q.forced_close_hours   <= FORCE_HOURS_RST;
			cfg_q.forced_close_hold    <= FORCE_HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRAVEL_STEPS: cfg_q.travel_steps         <= cfg_data;
				REG_STEP_PERIOD:  cfg_q.step_period_ticks    <= cfg_data[7:0];
				REG_CTRL_PERIOD:  cfg_q.control_period_ticks <= cfg_data[7:0];
				REG_HOUR_PERIODS: cfg_q.hour_periods         <= cfg_data;
				REG_FORCE_HOURS:  cfg_q.forced_close_hours   <= cfg_data[7:0];
				REG_FORCE_HOLD:   cfg_q.forced_close_hold    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			step_tick_q <= '0;
			ctrl_tick_q <= '0;
			motor_q     <= '0;
			timer_q     <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (work) begin
				step_tick_q <= step_tick_nxt;
				ctrl_tick_q <= ctrl_tick_nxt;
				motor_q     <= motor_upd;
				timer_q     <= timer_nxt;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_word;
		end
		if (work) begin
			result_q.coils           <= motor_nxt.coils;
			result_q.position        <= position_nxt;
			result_q.door_open       <= motor_nxt.open_flag;
			result_q.opening_latched <= motor_nxt.direction_latch;
			result_q.force_pending   <= timer_nxt.force_flag;
			result_q.force_active    <= (timer_nxt.hold_count != 16'd0);
		end
	end

endmodule

// ----- hw/rtl/dsh_motor.sv -----
// Step tick divider and one half step of the door motor.
module dsh_motor import dsh_pkg::*; (
	input  dsh_cfg_t   cfg,
	input  logic [7:0] step_tick,
	input  dsh_motor_t cur,
	input  logic [7:0] close_delay,
	input  logic       ice_out,
	output logic [7:0] step_tick_next,
	output dsh_motor_t nxt
);

	logic [7:0]  tick_inc;
	logic        fire;
	logic [15:0] pos;

	always_comb begin
		tick_inc       = step_tick + 8'd1;
		fire           = (tick_inc >= cfg.step_period_ticks);
		step_tick_next = fire ? 8'd0 : tick_inc;
		nxt            = cur;
		pos            = cur.position;
		if (fire) begin
			if (cur.open_flag) begin
				nxt.direction_latch = 1'b1;
				if (cur.position < cfg.travel_steps) begin
					pos = cur.position + 16'd1;
				end else begin
					pos = cfg.travel_steps;
					if (!ice_out) begin
						nxt.open_flag = 1'b0;
					end
				end
			end else begin
				// A reversal restarts the close run from full travel.
				if (cur.direction_latch) begin
					pos = cfg.travel_steps;
				end
				nxt.direction_latch = 1'b0;
				if (pos != 16'd0 && close_delay == 8'd0) begin
					pos = pos - 16'd1;
				end
			end
			nxt.position = pos;
			if (pos == 16'd0 || pos == cfg.travel_steps) begin
				nxt.coils = 4'h0;
			end else begin
				nxt.coils = phase_coils(pos[2:0]);
			end
		end
	end

endmodule

// ----- hw/rtl/dsh_timer.sv -----
// Control tick divider, close delay countdown and forced close idle timer.
module dsh_timer import dsh_pkg::*; (
	input  dsh_cfg_t   cfg,
	input  logic [7:0] ctrl_tick,
	input  dsh_timer_t cur,
	input  logic       ice_out,
	output logic [7:0] ctrl_tick_next,
	output dsh_timer_t nxt,
	output logic       load_travel
);

	logic [7:0]  tick_inc;
	logic        fire;
	logic [15:0] pc;
	logic [7:0]  hc;

	always_comb begin
		tick_inc       = (ctrl_tick < cfg.control_period_ticks) ? ctrl_tick + 8'd1 : ctrl_tick;
		fire           = (tick_inc >= cfg.control_period_ticks);
		ctrl_tick_next = fire ? 8'd0 : tick_inc;
		nxt            = cur;
		load_travel    = 1'b0;
		pc             = ice_out ? 16'd0 : cur.period_count;
		hc             = ice_out ? 8'd0 : cur.hour_count;
		if (fire) begin
			if (cur.close_delay != 8'd0) begin
				nxt.close_delay = cur.close_delay - 8'd1;
			end
			pc = pc + 16'd1;
			if (pc >= cfg.hour_periods) begin
				pc = 16'd0;
				hc = hc + 8'd1;
			end
			if (hc >= cfg.forced_close_hours) begin
				nxt.force_flag = 1'b1;
				hc             = 8'd0;
			end
			// A request pending at the start of this period starts the close run.
			if (cur.force_flag) begin
				nxt.force_flag = 1'b0;
				pc             = 16'd0;
				hc             = 8'd0;
				nxt.hold_count = cfg.forced_close_hold;
				load_travel    = 1'b1;
			end
			if (nxt.hold_count != 16'd0) begin
				nxt.hold_count = nxt.hold_count - 16'd1;
			end
			nxt.period_count = pc;
			nxt.hour_count   = hc;
		end
	end

endmodule

// ----- hw/rtl/dsh_checker.sv -----
// Port-level assertions for the door stepper controller and their bind.
module dsh_checker import dsh_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_stall,
	input dsh_in_t  in_word,
	input logic     out_valid,
	input logic     out_stall,
	input dsh_out_t out_word
);

	// A stalled tick word stays put.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_word))
		else $error("tick word changed while stalled");

	// A stalled result word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// With the output register empty the block never holds off a tick.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output register is empty");

	// Half stepping never drives more than two coils.
	a_coil_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones(out_word.coils) <= 2)
		else $error("more than two coils driven");

endmodule

bind door_stepper_half_step_controller dsh_checker u_dsh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);
